// ----- rtl/arpc_pkg.sv -----
// shared types and constants for the arp responder with ip-to-mac cache
// no dependencies; imported by arpc_cell and arp_responder_with_cache_core
package arpc_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = CFG_IDX_W'(1);

	localparam logic [15:0] HW_ETHERNET = 16'h0001;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [15:0] OP_REQUEST  = 16'h0001;

	localparam logic [2:0] ST_REPLY     = 3'd0;
	localparam logic [2:0] ST_BAD_HW    = 3'd1;
	localparam logic [2:0] ST_BAD_PROTO = 3'd2;
	localparam logic [2:0] ST_NOT_US    = 3'd3;
	localparam logic [2:0] ST_NOT_REQ   = 3'd4;
	localparam logic [2:0] ST_LOOKUP    = 3'd5;

	typedef struct packed {
		logic        req_type;
		logic [15:0] hw_kind;
		logic [15:0] proto_kind;
		logic [15:0] arp_op;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [31:0] tgt_ip;
		logic [31:0] query_ip;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        send_reply;
		logic [47:0] reply_sender_mac;
		logic [31:0] reply_sender_ip;
		logic [47:0] reply_target_mac;
		logic [31:0] reply_tgt_ip;
		logic [47:0] eth_dest_mac;
		logic        cache_learned;
		logic        table_full;
		logic        lookup_hit;
		logic [47:0] lookup_mac;
	} out_t;

	typedef enum logic [1:0] {
		TOK_NONE,
		TOK_LEARN,
		TOK_QUERY
	} tok_mode_t;

	// token walking down the cell row
	typedef struct packed {
		logic        vld;
		tok_mode_t   mode;
		logic [31:0] ip;
		logic [47:0] mac;
		logic        hit;
		logic [47:0] hit_mac;
	} tok_t;

endpackage

// ----- rtl/arpc_cell.sv -----
// one cache entry of the arp cache row; learns or answers the passing token
// depends on arpc_pkg
module arpc_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  arpc_pkg::tok_t up_tok,
	output arpc_pkg::tok_t down_tok
);
	import arpc_pkg::*;

	logic        ent_vld_q;
	logic [31:0] ent_ip_q;
	logic [47:0] ent_mac_q;
	tok_t        tok_q;
	tok_t        tok_d;
	logic        match;
	logic        wr;

	assign match = ent_vld_q && (ent_ip_q == up_tok.ip);

	// valid entries always form a prefix, so the first free cell comes after any match
	always_comb begin
		tok_d = up_tok;
		wr    = 1'b0;
		if (up_tok.vld && !up_tok.hit) begin
			case (up_tok.mode)
				TOK_LEARN: begin
					if (match || !ent_vld_q) begin
						wr        = 1'b1;
						tok_d.hit = 1'b1;
					end
				end
				TOK_QUERY: begin
					if (match) begin
						tok_d.hit     = 1'b1;
						tok_d.hit_mac = ent_mac_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
			tok_q     <= '0;
		end else begin
			tok_q <= tok_d;
			if (wr) begin
				ent_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_ip_q  <= up_tok.ip;
			ent_mac_q <= up_tok.mac;
		end
	end

	assign down_tok = tok_q;

`ifndef SYNTH
	a_vld_follows: assert property (@(posedge clk) disable iff (!arst_n)
		tok_q.vld |-> $past(up_tok.vld))
		else $error("token appeared without upstream token");
	a_entry_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ent_vld_q) |-> ent_vld_q)
		else $error("cache entry lost its valid bit");
	a_hit_kept: assert property (@(posedge clk) disable iff (!arst_n)
		$past(up_tok.vld && up_tok.hit) |-> tok_q.hit)
		else $error("token hit flag dropped in cell");
`endif

endmodule

// ----- rtl/arp_responder_with_cache_core.sv -----
// arp responder with ip-to-mac cache: one token walks a row of TABLE_ENTRIES cells
// path: launch register, one register per cell, pending register, output register
// one item in flight; the next item is accepted once the result reaches the
//   output register, which a low out_ready can hold
// reset: arst_n clears control, cache valid bits and registers own_ip and own_mac
// depends on arpc_pkg and arpc_cell
module arp_responder_with_cache_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  arpc_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output arpc_pkg::out_t                    out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [arpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [arpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import arpc_pkg::*;

	typedef struct packed {
		logic hw_ok;
		logic for_us;
		logic is_req;
	} desc_t;

	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;
	logic        busy_q;
	tok_t        launch_q;
	desc_t       desc_q;
	out_t        pend_q;
	logic        pend_vld_q;
	out_t        out_q;
	logic        out_valid_q;
	out_t        res;
	tok_t        chain_tok [TABLE_ENTRIES+1];
	tok_t        chain_out;
	logic        in_xfer;
	logic        hw_ok;
	logic        proto_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q;
	assign in_xfer   = in_valid && in_ready;
	assign hw_ok     = (in_data.hw_kind == HW_ETHERNET);
	assign proto_ok  = (in_data.proto_kind == PROTO_IPV4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OWN_IP:  own_ip_q  <= cfg_data[31:0];
				CFG_OWN_MAC: own_mac_q <= cfg_data[47:0];
				default: begin
				end
			endcase
		end
	end

	// launch register feeds the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
		end else begin
			launch_q.vld <= in_xfer;
			if (in_xfer) begin
				launch_q.hit     <= 1'b0;
				launch_q.hit_mac <= '0;
				launch_q.mac     <= in_data.sender_mac;
				if (in_data.req_type) begin
					launch_q.mode <= TOK_QUERY;
					launch_q.ip   <= in_data.query_ip;
				end else begin
					launch_q.mode <= (hw_ok && proto_ok) ? TOK_LEARN : TOK_NONE;
					launch_q.ip   <= in_data.sender_ip;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			desc_q.hw_ok  <= hw_ok;
			desc_q.for_us <= (in_data.tgt_ip == own_ip_q);
			desc_q.is_req <= (in_data.arp_op == OP_REQUEST);
		end
	end

	assign chain_tok[0] = launch_q;

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		arpc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_tok   (chain_tok[k]),
			.down_tok (chain_tok[k+1])
		);
	end

	assign chain_out = chain_tok[TABLE_ENTRIES];

	// when a reply is sent, a stored or updated sender reads back as its own mac
	always_comb begin
		res = '0;
		case (chain_out.mode)
			TOK_QUERY: begin
				res.status     = ST_LOOKUP;
				res.lookup_hit = chain_out.hit;
				res.lookup_mac = chain_out.hit ? chain_out.hit_mac : '0;
			end
			TOK_LEARN: begin
				res.cache_learned = chain_out.hit;
				res.table_full    = !chain_out.hit;
				if (!desc_q.for_us) begin
					res.status = ST_NOT_US;
				end else if (!desc_q.is_req) begin
					res.status = ST_NOT_REQ;
				end else begin
					res.status           = ST_REPLY;
					res.send_reply       = 1'b1;
					res.reply_sender_mac = own_mac_q;
					res.reply_sender_ip  = own_ip_q;
					res.reply_target_mac = chain_out.mac;
					res.reply_tgt_ip     = chain_out.ip;
					res.eth_dest_mac     = chain_out.mac;
					res.lookup_hit       = chain_out.hit;
					res.lookup_mac       = chain_out.hit ? chain_out.mac : '0;
				end
			end
			default: begin
				res.status = desc_q.hw_ok ? ST_BAD_PROTO : ST_BAD_HW;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				busy_q <= 1'b1;
			end
			if (chain_out.vld) begin
				pend_vld_q <= 1'b1;
			end
			if (pend_vld_q && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				pend_vld_q  <= 1'b0;
				busy_q      <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain_out.vld) begin
			pend_q <= res;
		end
		if (pend_vld_q && (!out_valid_q || out_ready)) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chain_out.vld |-> busy_q && !pend_vld_q)
		else $error("token left the cell row while not busy or result pending");
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> launch_q.vld && busy_q)
		else $error("accepted item was not launched");
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> busy_q && !launch_q.vld)
		else $error("pending result without busy item");
`endif

endmodule
